@@ hw/rtl/assert_macros.svh @@
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is high.
`define ASSERT_CLK_RST(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");

// Clocked assertion that also holds during reset.
`define ASSERT_CLK(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("assertion failed");

`endif

@@ hw/rtl/kppi_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package kppi_pkg;

  // Width of the length register and of run and prefix lengths.
  localparam int LEN_W = 4;

  // Reset value of the length register before clamping to the built maximum.
  localparam logic [LEN_W-1:0] MER_RESET = 4'd8;

  // Item kinds.
  localparam logic FUNC_SCAN  = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_QREAD,
    ST_QDONE
  } state_t;

  typedef struct packed {
    logic load;
    logic scan_wr;
    logic q_rd;
    logic out_load;
    logic clr_step;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic out_free;
  } status_t;

endpackage

`default_nettype wire

@@ hw/rtl/kppi_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none

module kppi_ctrl (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  input  wire logic             func,
  output logic                  in_ready,
  input  kppi_pkg::status_t     status,
  output kppi_pkg::cmd_t        cmd
);
  import kppi_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: begin
        if (status.clr_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          state_next = (func == FUNC_QUERY) ? ST_QREAD : ST_SCAN;
        end
      end
      ST_SCAN: begin
        state_next = ST_IDLE;
      end
      ST_QREAD: begin
        state_next = ST_QDONE;
      end
      ST_QDONE: begin
        if (status.out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
  end

  always_comb begin
    in_ready     = 1'b0;
    cmd          = '0;
    unique case (state)
      ST_CLEAR: begin
        cmd.clr_step = 1'b1;
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ST_SCAN: begin
        cmd.scan_wr = 1'b1;
      end
      ST_QREAD: begin
        cmd.q_rd = 1'b1;
      end
      ST_QDONE: begin
        cmd.out_load = status.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

`default_nettype wire

@@ hw/rtl/kppi_datapath.sv @@
`timescale 1ns / 1ps
`default_nettype none

module kppi_datapath #(
  parameter int MAX_MER = 8
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  kppi_pkg::cmd_t                  cmd,
  output kppi_pkg::status_t               status,
  input  wire logic [1:0]                 base_code,
  input  wire logic                       base_valid,
  input  wire logic [15:0]                kmer_code,
  input  wire logic                       cfg_we,
  input  wire logic [kppi_pkg::LEN_W-1:0] cfg_wdata,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic [kppi_pkg::LEN_W-1:0]      prefix_length
);
  import kppi_pkg::*;

  localparam int KW = 2 * MAX_MER;
  localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_MER);
  localparam logic [LEN_W-1:0] MER_INIT = (MER_RESET > MAX_LEN) ? MAX_LEN : MER_RESET;

  logic [LEN_W-1:0] kmer_len;
  logic [LEN_W-1:0] k_eff;
  logic [1:0]       item_base;
  logic             item_bvalid;
  logic [KW-1:0]    item_kmer;
  logic [KW+15:0]   kmer_wide;
  logic [KW-1:0]    recent_bases;
  logic [KW-1:0]    recent_next;
  logic [KW+1:0]    recent_shift;
  logic [LEN_W-1:0] run_length;
  logic [LEN_W-1:0] run_next;
  logic [KW-1:0]    clr_addr;
  logic [MAX_MER-1:0] hit;
  logic [LEN_W-1:0] result;

  always_ff @(posedge clk) begin
    if (rst) begin
      kmer_len <= MER_INIT;
    end else if (cfg_we) begin
      kmer_len <= cfg_wdata;
    end
  end

  always_comb begin
    if (kmer_len == '0) begin
      k_eff = LEN_W'(1);
    end else if (kmer_len > MAX_LEN) begin
      k_eff = MAX_LEN;
    end else begin
      k_eff = kmer_len;
    end
  end

  assign kmer_wide = {{KW{1'b0}}, kmer_code};

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_base   <= base_code;
      item_bvalid <= base_valid;
      item_kmer   <= kmer_wide[KW-1:0];
    end
  end

  assign recent_shift = {recent_bases, item_base};
  assign recent_next  = recent_shift[KW-1:0];
  assign run_next     = (run_length < MAX_LEN) ? run_length + LEN_W'(1) : run_length;

  always_ff @(posedge clk) begin
    if (rst) begin
      recent_bases <= '0;
      run_length   <= '0;
    end else if (cmd.scan_wr) begin
      if (item_bvalid) begin
        recent_bases <= recent_next;
        run_length   <= run_next;
      end else begin
        run_length <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (cmd.clr_step) begin
      clr_addr <= clr_addr + KW'(1);
    end
  end

  // One presence bank per length, all marked or read in the same cycle.
  for (genvar g = 0; g < MAX_MER; g++) begin : g_bank
    localparam int J = g + 1;
    localparam logic [LEN_W-1:0] JL = LEN_W'(J);

    logic             mem [0:(2**(2*J))-1];
    logic             wr_en;
    logic             wr_data;
    logic [2*J-1:0]   wr_addr;
    logic [2*J-1:0]   rd_addr;
    logic [LEN_W:0]   shamt;
    logic [KW-1:0]    prefix;
    logic             rd_bit;

    always_comb begin
      if (cmd.clr_step) begin
        wr_en   = 1'b1;
        wr_data = 1'b0;
        wr_addr = clr_addr[2*J-1:0];
      end else begin
        wr_en   = cmd.scan_wr && item_bvalid && (JL <= k_eff) && (JL <= run_next);
        wr_data = 1'b1;
        wr_addr = recent_next[2*J-1:0];
      end
    end

    always_comb begin
      if (JL > k_eff) begin
        shamt = '0;
      end else begin
        shamt = {k_eff - JL, 1'b0};
      end
      prefix  = item_kmer >> shamt;
      rd_addr = prefix[2*J-1:0];
    end

    always_ff @(posedge clk) begin
      if (wr_en) begin
        mem[wr_addr] <= wr_data;
      end
      if (cmd.q_rd) begin
        rd_bit <= mem[rd_addr];
      end
    end

    assign hit[g] = rd_bit;
  end

  // Longest length up to k whose bank reported a hit; zero if none did.
  always_comb begin
    result = '0;
    for (int j = 1; j <= MAX_MER; j++) begin
      if (hit[j-1] && (LEN_W'(j) <= k_eff)) begin
        result = LEN_W'(j);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      prefix_length <= result;
    end
  end

  assign status.clr_last = &clr_addr;
  assign status.out_free = !out_valid || out_ready;

endmodule

`default_nettype wire

@@ hw/rtl/kmer_prefix_presence_index.sv @@
// Scan item: accepted when idle, bitmaps marked in the next cycle; no item is taken then.
// Query item: accepted, banks read, then result registered into the output register once
// that is free; no new item is accepted until the query has passed its read and done states.
// Reset (rst, synchronous, active high) starts a clearing pass over all banks; no item
// is accepted until it has finished.
`timescale 1ns / 1ps
`default_nettype none

module kmer_prefix_presence_index #(
  parameter int MAX_MER = 8
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  // Input item channel.
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire logic                       func,
  input  wire logic [1:0]                 base_code,
  input  wire logic                       base_valid,
  input  wire logic [15:0]                kmer_code,
  // Result item channel.
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic [kppi_pkg::LEN_W-1:0]      prefix_length,
  // Length register write port.
  input  wire logic                       cfg_we,
  input  wire logic [kppi_pkg::LEN_W-1:0] cfg_wdata
);
  import kppi_pkg::*;

  // The controller sequences each item through clear, scan or query states.
  // The datapath holds one presence bank per length so that all lengths are
  // marked by a scan in the same cycle and all prefixes of a query are read
  // together; the longest hit is then picked from the registered read bits.
  // A finished result sits in the output register, and scans keep flowing
  // while it waits; a second query waits in its final state until the
  // register frees up.

  cmd_t    cmd;
  status_t status;

  kppi_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .func     (func),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  kppi_datapath #(
    .MAX_MER (MAX_MER)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .base_code     (base_code),
    .base_valid    (base_valid),
    .kmer_code     (kmer_code),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .prefix_length (prefix_length)
  );

endmodule

`default_nettype wire

@@ hw/rtl/kppi_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module kppi_checker #(
  parameter int MAX_MER = 8
) (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        func,
  input wire logic [1:0]  base_code,
  input wire logic        base_valid,
  input wire logic [15:0] kmer_code,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [3:0]  prefix_length,
  input wire logic        cfg_we,
  input wire logic [3:0]  cfg_wdata
);
  localparam logic [3:0] MAX_LEN = 4'(MAX_MER);
  localparam logic [3:0] K_INIT = (4'd8 > MAX_LEN) ? MAX_LEN : 4'd8;

  logic [3:0] k_seen;
  logic [3:0] k_eff;
  logic       unused_ok;

  // Track the effective length from the write port.
  always_ff @(posedge clk) begin
    if (rst) begin
      k_seen <= K_INIT;
    end else if (cfg_we) begin
      k_seen <= cfg_wdata;
    end
  end

  assign k_eff = (k_seen == 4'd0) ? 4'd1 : ((k_seen > MAX_LEN) ? MAX_LEN : k_seen);
  assign unused_ok = ^{func, base_code, base_valid, kmer_code};

  `ASSERT_CLK_RST(a_out_hold, clk, rst, out_valid && !out_ready |=> out_valid && $stable(prefix_length))
  `ASSERT_CLK_RST(a_len_bound, clk, rst, out_valid |-> prefix_length <= k_eff)
  `ASSERT_CLK(a_reset_quiet, clk, rst |=> !out_valid && !in_ready)
  `ASSERT_CLK_RST(a_one_at_a_time, clk, rst, in_valid && in_ready |=> !in_ready || unused_ok != unused_ok)

endmodule

bind kmer_prefix_presence_index kppi_checker #(.MAX_MER(MAX_MER)) u_kppi_checker (.*);

`default_nettype wire

@@ tb/sv/kppi_result_checker.sv @@
`timescale 1ns / 1ps

module kppi_result_checker #(
  parameter int MAX_MER = 8
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  input  logic                       in_ready,
  input  logic                       func,
  input  logic [1:0]                 base_code,
  input  logic                       base_valid,
  input  logic [15:0]                kmer_code,
  input  logic                       out_valid,
  input  logic                       out_ready,
  input  logic [kppi_pkg::LEN_W-1:0] prefix_length,
  input  logic                       cfg_we,
  input  logic [kppi_pkg::LEN_W-1:0] cfg_wdata,
  output int                         fail_count,
  output int                         outstanding
);
  import kppi_pkg::*;

  localparam int CODES = 4 ** MAX_MER;

  // One presence bitmap per length; shorter lengths use the low part of a row.
  bit presence_map [1:MAX_MER][0:CODES-1];
  bit map_touched;
  logic [2*MAX_MER-1:0] base_history;
  logic [LEN_W-1:0] run_count;
  logic [LEN_W-1:0] kmer_len;
  logic [LEN_W-1:0] expected_lengths [$];

  function automatic int unsigned active_length();
    if (kmer_len == 0) return 1;
    if (kmer_len > MAX_MER) return MAX_MER;
    return kmer_len;
  endfunction

  function automatic void mark_scanned_base(logic [1:0] code);
    int unsigned k;
    k = active_length();
    base_history = (base_history << 2) | code;
    if (run_count < MAX_MER) run_count++;
    for (int j = 1; j <= k && j <= run_count; j++)
      presence_map[j][base_history & ((1 << (2 * j)) - 1)] = 1'b1;
    map_touched = 1'b1;
  endfunction

  // Longest prefix of the k-mer whose bit is set, searching from k down to 1.
  function automatic logic [LEN_W-1:0] longest_prefix(logic [15:0] kmer);
    int k;
    int unsigned code;
    k = active_length();
    code = kmer & ((1 << (2 * k)) - 1);
    for (int j = k; j >= 1; j--)
      if (presence_map[j][code >> (2 * (k - j))]) return LEN_W'(j);
    return '0;
  endfunction

  always @(posedge clk) begin
    logic [LEN_W-1:0] want;
    if (rst) begin
      if (map_touched) begin
        for (int j = 1; j <= MAX_MER; j++)
          for (int c = 0; c < CODES; c++) presence_map[j][c] = 1'b0;
      end
      map_touched = 1'b0;
      base_history = '0;
      run_count = '0;
      kmer_len = MER_RESET;
      expected_lengths.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (expected_lengths.size() == 0) begin
          $display("%0t: prefix_length %0d arrived with no query waiting, expected none",
                   $time, prefix_length);
          fail_count++;
        end else begin
          want = expected_lengths.pop_front();
          if (prefix_length !== want) begin
            $display("%0t: prefix_length mismatch, expected %0d, actual %0d",
                     $time, want, prefix_length);
            fail_count++;
          end
        end
      end
      if (in_valid && in_ready) begin
        if (func == FUNC_QUERY) expected_lengths.push_back(longest_prefix(kmer_code));
        else if (base_valid) mark_scanned_base(base_code);
        else run_count = '0;
      end
      if (cfg_we) kmer_len = cfg_wdata;
    end
    outstanding <= expected_lengths.size();
  end

endmodule

@@ tb/sv/tb_kmer_prefix_presence_index.sv @@
`timescale 1ns / 1ps

module tb_kmer_prefix_presence_index;
  import kppi_pkg::*;

  localparam int MAX_MER = 8;
  // The bound lies far above the length of a correct run, clearing pass included,
  // so it only catches a hung block.
  localparam int CYCLE_LIMIT = 1_000_000;
  // Cycles allowed after the last result before the block counts as idle. A scan
  // produces no result but still writes the bitmaps in the cycle after acceptance.
  localparam int SETTLE_CYCLES = 8;
  localparam int PHASE_ITEMS = 168;
  // The long receiver hold-off starts once this many items have gone in.
  localparam int HOLD_AFTER_ITEMS = 700;
  localparam int HOLD_CYCLES = 300;
  // Recently scanned valid bases, used to build queries that hit the bitmaps.
  localparam int HISTORY_DEPTH = 64;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic func = FUNC_SCAN;
  logic [1:0] base_code = '0;
  logic base_valid = 1'b0;
  logic [15:0] kmer_code = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [LEN_W-1:0] prefix_length;
  logic cfg_we = 1'b0;
  logic [LEN_W-1:0] cfg_wdata = '0;

  int fail_count;
  int outstanding;
  int items_sent = 0;
  int cycle_count = 0;
  // The k that the block applies after clamping the length register.
  int unsigned active_k = MAX_MER;
  logic [1:0] scanned_bases [$];

  kmer_prefix_presence_index #(
    .MAX_MER(MAX_MER)
  ) dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .func(func),
    .base_code(base_code),
    .base_valid(base_valid),
    .kmer_code(kmer_code),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .prefix_length(prefix_length),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  // The checker sees the same pins as the block, keeps its own copy of the
  // bitmaps and scores every result. It reports how many queries are still
  // waiting for a result so that the stimulus knows when the block is drained.
  kppi_result_checker #(
    .MAX_MER(MAX_MER)
  ) result_checker (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .func(func),
    .base_code(base_code),
    .base_valid(base_valid),
    .kmer_code(kmer_code),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .prefix_length(prefix_length),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata),
    .fail_count(fail_count),
    .outstanding(outstanding)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Reset is held once, at the start.
  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
  end

  // A hung handshake ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Offers one item and holds it until the block takes it. The payload and valid
  // are only changed at a rising edge, and valid stays high from one item to the
  // next when there is no gap between them.
  task automatic send_item(input logic kind, input logic [1:0] code, input logic ok,
                           input logic [15:0] kmer);
    func <= kind;
    base_code <= code;
    base_valid <= ok;
    kmer_code <= kmer;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
  endtask

  // A scan item carries a random k-mer code, which the block must ignore.
  task automatic scan_base(input logic [1:0] code, input logic ok);
    send_item(FUNC_SCAN, code, ok, 16'($urandom));
    if (ok) begin
      scanned_bases.push_back(code);
      if (scanned_bases.size() > HISTORY_DEPTH) void'(scanned_bases.pop_front());
    end
  endtask

  // A query item carries random base fields, which the block must ignore.
  task automatic query_kmer(input logic [15:0] kmer);
    send_item(FUNC_QUERY, 2'($urandom), 1'($urandom), kmer);
  endtask

  task automatic pause_input(input int unsigned cycles);
    in_valid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // Stops offering items and waits until every query has been answered and the
  // last scan has had time to mark its bits.
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // The length register is only written while the block is idle.
  task automatic write_kmer_len(input logic [LEN_W-1:0] value);
    wait_idle();
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    active_k = (value == 0) ? 1 : (value > MAX_MER) ? MAX_MER : value;
  endtask

  // Most queries are windows of recently scanned bases, half of them with one
  // base changed, so that every prefix length turns up. The bits above 2k stay
  // random since the block must ignore them. The rest are fully random codes.
  function automatic logic [15:0] pick_query();
    logic [15:0] code;
    int unsigned start;
    int unsigned pos;
    code = 16'($urandom);
    if (scanned_bases.size() >= active_k && $urandom_range(0, 3) != 0) begin
      start = $urandom_range(0, scanned_bases.size() - active_k);
      for (int i = 0; i < active_k; i++)
        code[2*(active_k-1-i) +: 2] = scanned_bases[start + i];
      if ($urandom_range(0, 1) == 1) begin
        pos = $urandom_range(0, active_k - 1);
        code[2*(active_k-1-pos) +: 2] ^= 2'($urandom_range(1, 3));
      end
    end
    return code;
  endfunction

  // Random items in bursts of random length, with random gaps between bursts and
  // some bursts following each other back to back. Runs of valid bases dominate,
  // broken now and then by an invalid character. A reduced alphabet in some
  // phases makes repeats, and so long prefix matches, more likely.
  task automatic random_phase(input int count);
    int burst_left;
    int unsigned pick;
    int unsigned alphabet_top;
    burst_left = 0;
    alphabet_top = $urandom_range(1, 3);
    for (int n = 0; n < count; n++) begin
      if (burst_left == 0) begin
        if ($urandom_range(0, 3) != 0) pause_input($urandom_range(1, 12));
        burst_left = $urandom_range(1, 30);
      end
      burst_left--;
      pick = $urandom_range(0, 99);
      if (pick < 55) scan_base(2'($urandom_range(0, alphabet_top)), 1'b1);
      else if (pick < 60) scan_base(2'($urandom), 1'b0);
      else query_kmer(pick_query());
    end
  endtask

  // The receiver runs in segments of random length, each with its own pattern:
  // always ready, ready at random, rarely ready, or alternating ready and not ready.
  // Once, after enough items have gone in, it holds off for a long stretch while
  // the sender keeps offering, so the block fills up and stalls its input.
  initial begin : result_sink
    int unsigned pattern;
    int unsigned segment;
    bit held;
    held = 1'b0;
    wait (!rst);
    forever begin
      pattern = $urandom_range(0, 3);
      segment = $urandom_range(20, 150);
      repeat (segment) begin
        if (!held && items_sent >= HOLD_AFTER_ITEMS) begin
          held = 1'b1;
          out_ready <= 1'b0;
          repeat (HOLD_CYCLES) @(posedge clk);
        end
        case (pattern)
          0: begin
            out_ready <= 1'b1;
          end
          1: begin
            out_ready <= 1'($urandom);
          end
          2: begin
            out_ready <= ($urandom_range(0, 4) == 0);
          end
          default: begin
            out_ready <= ~out_ready;
          end
        endcase
        @(posedge clk);
      end
    end
  end

  initial begin : stimulus
    logic [LEN_W-1:0] settings [10];
    settings = '{4'd3, 4'd15, 4'd5, 4'd2, 4'd0, 4'd7, 4'd4, 4'd8, 4'd6, 4'd1};
    wait (!rst);

    // Directed part, at the reset length of eight. Nothing has been scanned yet,
    // so the first query must stop at length zero.
    query_kmer(16'h0000);
    // A C G T T G C A, all four codes, with one full-length run.
    scan_base(2'd0, 1'b1);
    scan_base(2'd1, 1'b1);
    scan_base(2'd2, 1'b1);
    scan_base(2'd3, 1'b1);
    scan_base(2'd3, 1'b1);
    scan_base(2'd2, 1'b1);
    scan_base(2'd1, 1'b1);
    scan_base(2'd0, 1'b1);
    // The whole run, the run with its last base changed, and all ones.
    query_kmer(16'h1BE4);
    query_kmer(16'h1BE7);
    query_kmer(16'hFFFF);
    // An invalid character restarts the run: the G that follows must not form
    // a two-base string with the A before the break.
    scan_base(2'd3, 1'b0);
    scan_base(2'd2, 1'b1);
    query_kmer(16'h2000);

    // Length one; the code bits above the single base must be ignored.
    write_kmer_len(4'd1);
    query_kmer(16'hFFFE);
    scan_base(2'd3, 1'b1);
    query_kmer(16'h5553);
    // A zero register acts as length one.
    write_kmer_len(4'd0);
    query_kmer(16'h0001);
    // A value above the built maximum acts as the maximum.
    write_kmer_len(4'd15);
    query_kmer(16'h1BE4);

    // Random part: one phase per length setting. The run of valid bases carries
    // over each register change, so lengths change in the middle of a scan.
    foreach (settings[i]) begin
      write_kmer_len(settings[i]);
      random_phase(PHASE_ITEMS);
    end

    wait_idle();
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+hw/rtl
hw/rtl/kppi_pkg.sv
hw/rtl/kppi_ctrl.sv
hw/rtl/kppi_datapath.sv
hw/rtl/kmer_prefix_presence_index.sv
hw/rtl/kppi_checker.sv
tb/sv/kppi_result_checker.sv
tb/sv/tb_kmer_prefix_presence_index.sv
